FILE: sv/rgb2hsl_pkg.sv
// Shared widths, constants and the front-end result type for the RGB to HSL converter.
package rgb2hsl_pkg;

    localparam int RGB_W  = 8;   // colour level width
    localparam int HUE_W  = 15;  // hue in degrees, 6 fraction bits
    localparam int PCT_W  = 13;  // percent, 6 fraction bits
    localparam int QUO_W  = 15;  // quotient bits produced by each divider
    localparam int HNUM_W = 24;  // hue dividend width
    localparam int SNUM_W = 22;  // saturation dividend width
    localparam int DEN_W  = 9;   // divisor width for both dividers

    localparam int FRONT_STAGES = 2;
    localparam int PIPE_DEPTH   = FRONT_STAGES + QUO_W + 1;

    // Hue dividend is 2 * 3840 * x + d, saturation dividend 2 * 6400 * d + span.
    localparam logic [12:0] HUE_NUM_SCALE = 13'd7680;
    localparam logic [13:0] SAT_NUM_SCALE = 14'd12800;

    localparam logic [HUE_W-1:0] HUE_FULL_TURN = 15'd23040;
    localparam logic [PCT_W-1:0] PCT_FULL      = 13'd6400;

    // Lightness is floor((6400 * sum + 255) / 510), done as a multiply by the
    // reciprocal ceil(2^32 / 510) = 8421505, folded into one constant product.
    localparam int          LIGHT_SHIFT = 32;
    localparam int          LIGHT_W     = 46;
    localparam logic [35:0] LIGHT_MUL   = 36'd53897632000;
    localparam logic [31:0] LIGHT_ADD   = 32'd2147483775;

    typedef struct packed {
        logic [HNUM_W-1:0] hue_num;
        logic [DEN_W-1:0]  hue_den;
        logic [SNUM_W-1:0] sat_num;
        logic [DEN_W-1:0]  sat_den;
        logic [PCT_W-1:0]  light;
    } t_front_out;

endpackage

FILE: sv/rgb2hsl_front.sv
// Front end: maximum and minimum search, lightness, and divider operand set-up.
module rgb2hsl_front
    import rgb2hsl_pkg::*;
(
    input  logic             i_clk,
    input  logic [1:0]       i_en,
    input  logic [RGB_W-1:0] i_red_level,
    input  logic [RGB_W-1:0] i_green_level,
    input  logic [RGB_W-1:0] i_blue_level,
    output t_front_out       o_front
);

    localparam logic [1:0] SEL_RED   = 2'd0;
    localparam logic [1:0] SEL_GREEN = 2'd1;
    localparam logic [1:0] SEL_BLUE  = 2'd2;

    // First stage: the maximum and which channel holds it, the minimum, and the matching difference.
    logic [RGB_W-1:0]        r_hi, r_lo, n_hi, n_lo;
    logic signed [RGB_W:0]   r_diff, n_diff;
    logic [1:0]              r_sel, n_sel;

    always_comb begin
        if (i_red_level >= i_green_level && i_red_level >= i_blue_level) begin
            n_sel  = SEL_RED;
            n_hi   = i_red_level;
            n_diff = $signed({1'b0, i_green_level}) - $signed({1'b0, i_blue_level});
        end else if (i_green_level >= i_blue_level) begin
            n_sel  = SEL_GREEN;
            n_hi   = i_green_level;
            n_diff = $signed({1'b0, i_blue_level}) - $signed({1'b0, i_red_level});
        end else begin
            n_sel  = SEL_BLUE;
            n_hi   = i_blue_level;
            n_diff = $signed({1'b0, i_red_level}) - $signed({1'b0, i_green_level});
        end
        n_lo = i_red_level;
        if (i_green_level < n_lo) begin
            n_lo = i_green_level;
        end
        if (i_blue_level < n_lo) begin
            n_lo = i_blue_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_hi   <= n_hi;
            r_lo   <= n_lo;
            r_diff <= n_diff;
            r_sel  <= n_sel;
        end
    end

    // Second stage: delta, span, hue offset, lightness and the rounded operands.
    logic [RGB_W-1:0]    delta;
    logic [RGB_W:0]      sum;
    logic [RGB_W-1:0]    span;
    logic [10:0]         sector_d;
    logic signed [11:0]  hue_x_s;
    logic [10:0]         hue_x;
    logic [LIGHT_W-1:0]  light_prod;
    t_front_out          n_front, r_front;

    always_comb begin
        delta = r_hi - r_lo;
        sum   = {1'b0, r_hi} + {1'b0, r_lo};
        span  = (sum <= 9'd255) ? sum[RGB_W-1:0] : RGB_W'(9'd510 - sum);

        unique case (r_sel)
            SEL_RED:   sector_d = (r_diff < 0) ? (11'(delta) << 2) + (11'(delta) << 1)
                                               : 11'd0;
            SEL_GREEN: sector_d = 11'(delta) << 1;
            SEL_BLUE:  sector_d = 11'(delta) << 2;
            default:   sector_d = 11'd0;
        endcase
        hue_x_s = 12'(r_diff) + $signed({1'b0, sector_d});
        hue_x   = hue_x_s[10:0];

        light_prod = LIGHT_W'(sum) * LIGHT_W'(LIGHT_MUL) + LIGHT_W'(LIGHT_ADD);
        n_front.light = light_prod[LIGHT_SHIFT +: PCT_W];

        if (delta == '0) begin
            // Grey pixel: zero over one yields zero hue and saturation.
            n_front.hue_num = '0;
            n_front.hue_den = DEN_W'(1);
            n_front.sat_num = '0;
            n_front.sat_den = DEN_W'(1);
        end else begin
            n_front.hue_num = HNUM_W'(hue_x) * HNUM_W'(HUE_NUM_SCALE) + HNUM_W'(delta);
            n_front.hue_den = {delta, 1'b0};
            n_front.sat_num = SNUM_W'(delta) * SNUM_W'(SAT_NUM_SCALE) + SNUM_W'(span);
            n_front.sat_den = {span, 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_front <= n_front;
        end
    end

    assign o_front = r_front;

endmodule

FILE: sv/rgb2hsl_div.sv
// Pipelined restoring divider: one quotient bit per register stage.
module rgb2hsl_div #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 9,
    parameter int QUO_W = 15
) (
    input  logic             i_clk,
    input  logic [QUO_W-1:0] i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo
);

    // Partial remainders and divisors are only needed up to the last stage.
    logic [DEN_W-1:0] r_rem [QUO_W-1];
    logic [DEN_W-1:0] r_den [QUO_W-1];
    logic [QUO_W-1:0] r_nq  [QUO_W];

    logic [DEN_W-1:0] stg_rem [QUO_W];
    logic [DEN_W-1:0] stg_den [QUO_W];
    logic [QUO_W-1:0] stg_nq  [QUO_W];

    // The quotient fits in QUO_W bits, so the upper dividend bits start below the divisor.
    always_comb begin
        stg_rem[0] = DEN_W'(i_num >> QUO_W);
        stg_den[0] = i_den;
        stg_nq[0]  = i_num[QUO_W-1:0];
        for (int j = 1; j < QUO_W; j++) begin
            stg_rem[j] = r_rem[j-1];
            stg_den[j] = r_den[j-1];
            stg_nq[j]  = r_nq[j-1];
        end
    end

    for (genvar j = 0; j < QUO_W; j++) begin : g_stage
        logic [DEN_W:0] trial;
        logic           fits;

        assign trial = {stg_rem[j], stg_nq[j][QUO_W-1]};
        assign fits  = (trial >= {1'b0, stg_den[j]});

        always_ff @(posedge i_clk) begin
            if (i_en[j]) begin
                r_nq[j] <= {stg_nq[j][QUO_W-2:0], fits};
            end
        end

        if (j < QUO_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en[j]) begin
                    r_rem[j] <= fits ? DEN_W'(trial - {1'b0, stg_den[j]}) : trial[DEN_W-1:0];
                    r_den[j] <= stg_den[j];
                end
            end
        end
    end

    assign o_quo = r_nq[QUO_W-1];

endmodule

FILE: sv/rgb_to_hsl_convert.sv
// RGB to HSL pixel converter, top level.
// The pipeline has two front-end stages, fifteen divider stages and one output stage.
// Throughput is one pixel per cycle while the output is not stalled; each stage
// advances when it is empty or the stage after it advances, so bubbles close up
// while the output is stalled.
// Synchronous active-low reset clears the valid bits only; data registers are not reset.
module rgb_to_hsl_convert
    import rgb2hsl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [RGB_W-1:0] i_red_level,
    input  logic [RGB_W-1:0] i_green_level,
    input  logic [RGB_W-1:0] i_blue_level,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [HUE_W-1:0] o_hue_angle,
    output logic [PCT_W-1:0] o_saturation_pct,
    output logic [PCT_W-1:0] o_lightness_pct
);

    logic [PIPE_DEPTH-1:0] r_vld, n_vld, stg_en;

    always_comb begin
        stg_en[PIPE_DEPTH-1] = !r_vld[PIPE_DEPTH-1] || !i_stall;
        for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
            stg_en[k] = !r_vld[k] || stg_en[k+1];
        end
        n_vld = r_vld;
        if (stg_en[0]) begin
            n_vld[0] = i_valid;
        end
        for (int k = 1; k < PIPE_DEPTH; k++) begin
            if (stg_en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_stall = !stg_en[0];
    assign o_valid = r_vld[PIPE_DEPTH-1];

    t_front_out front;

    rgb2hsl_front u_front (
        .i_clk         (i_clk),
        .i_en          (stg_en[1:0]),
        .i_red_level   (i_red_level),
        .i_green_level (i_green_level),
        .i_blue_level  (i_blue_level),
        .o_front       (front)
    );

    logic [QUO_W-1:0] hue_quo, sat_quo;

    rgb2hsl_div #(
        .NUM_W (HNUM_W),
        .DEN_W (DEN_W),
        .QUO_W (QUO_W)
    ) u_hue_div (
        .i_clk (i_clk),
        .i_en  (stg_en[FRONT_STAGES +: QUO_W]),
        .i_num (front.hue_num),
        .i_den (front.hue_den),
        .o_quo (hue_quo)
    );

    rgb2hsl_div #(
        .NUM_W (SNUM_W),
        .DEN_W (DEN_W),
        .QUO_W (QUO_W)
    ) u_sat_div (
        .i_clk (i_clk),
        .i_en  (stg_en[FRONT_STAGES +: QUO_W]),
        .i_num (front.sat_num),
        .i_den (front.sat_den),
        .o_quo (sat_quo)
    );

    // Lightness is ready after the front end and rides alongside the dividers.
    logic [PCT_W-1:0] r_light [QUO_W];

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < QUO_W; j++) begin
            if (stg_en[FRONT_STAGES + j]) begin
                r_light[j] <= (j == 0) ? front.light : r_light[(j == 0) ? 0 : j - 1];
            end
        end
    end

    logic [HUE_W-1:0] hue_wrapped;

    assign hue_wrapped = (hue_quo >= HUE_FULL_TURN) ? hue_quo - HUE_FULL_TURN : hue_quo;

    logic [HUE_W-1:0] r_hue;
    logic [PCT_W-1:0] r_sat, r_light_out;

    always_ff @(posedge i_clk) begin
        if (stg_en[PIPE_DEPTH-1]) begin
            r_hue       <= hue_wrapped;
            r_sat       <= PCT_W'(sat_quo);
            r_light_out <= r_light[QUO_W-1];
        end
    end

    assign o_hue_angle      = r_hue;
    assign o_saturation_pct = r_sat;
    assign o_lightness_pct  = r_light_out;

    // A free-running output side must never hold off a new request.
    a_no_stall_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled although the output side is not stalled");

    // Stalling the input is only justified by a full first stage.
    a_stall_needs_full_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_vld[0])
        else $error("input stalled with an empty first stage");

    a_hue_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hue_angle < HUE_FULL_TURN))
        else $error("hue not wrapped below a full turn");

    a_pct_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_saturation_pct <= PCT_FULL) && (o_lightness_pct <= PCT_FULL))
        else $error("saturation or lightness above one hundred percent");

endmodule

FILE: test/tb.sv
// Self-checking testbench for the RGB to HSL pixel converter.
`timescale 1ns / 100ps

module tb;
    import rgb2hsl_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned RANDOM_PIXELS = 1450;
    localparam int unsigned MAX_GAP = 12;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [PCT_W-1:0] sat;
        logic [PCT_W-1:0] light;
    } t_hsl;

    class hsl_scoreboard;
        t_hsl        expected_hsl[$];
        int unsigned pixels_in;
        int unsigned results_checked;
        int unsigned mismatches;

        // Exact integer ratios, rounded to nearest with halves going up.
        function t_hsl hsl_from_rgb(bit [RGB_W-1:0] r, bit [RGB_W-1:0] g,
                                    bit [RGB_W-1:0] b);
            int unsigned top;
            int unsigned bottom;
            int unsigned delta;
            int unsigned total;
            int unsigned span;
            int unsigned hue_num;
            int unsigned hue;
            t_hsl        res;
            top = 32'(r);
            bottom = 32'(r);
            if (g > top) top = 32'(g);
            if (b > top) top = 32'(b);
            if (g < bottom) bottom = 32'(g);
            if (b < bottom) bottom = 32'(b);
            delta = top - bottom;
            total = top + bottom;
            res.light = PCT_W'((2 * total * 3200 + 255) / 510);
            res.sat = '0;
            res.hue = '0;
            if (delta != 0) begin
                span = (total <= 255) ? total : 510 - total;
                res.sat = PCT_W'((2 * delta * 6400 + span) / (2 * span));
                if (top == r) begin
                    if (g >= b)
                        hue_num = 3840 * (g - b);
                    else
                        hue_num = 23040 * delta - 3840 * (b - g);
                end else if (top == g) begin
                    hue_num = 3840 * (b + 2 * delta - r);
                end else begin
                    hue_num = 3840 * (r + 4 * delta - g);
                end
                hue = (2 * hue_num + delta) / (2 * delta);
                if (hue >= 23040) hue = hue - 23040;
                res.hue = HUE_W'(hue);
            end
            return res;
        endfunction

        function void note_pixel(bit [RGB_W-1:0] r, bit [RGB_W-1:0] g,
                                 bit [RGB_W-1:0] b);
            expected_hsl.push_back(hsl_from_rgb(r, g, b));
            pixels_in++;
        endfunction

        function void check_result(t_hsl got);
            t_hsl want;
            if (expected_hsl.size() == 0) begin
                $display("%0t: unexpected result hue=%0d sat=%0d light=%0d",
                         $time, got.hue, got.sat, got.light);
                mismatches++;
                return;
            end
            want = expected_hsl.pop_front();
            results_checked++;
            if (got.hue !== want.hue) begin
                $display("%0t: hue mismatch: expected %0d, actual %0d",
                         $time, want.hue, got.hue);
                mismatches++;
            end
            if (got.sat !== want.sat) begin
                $display("%0t: saturation mismatch: expected %0d, actual %0d",
                         $time, want.sat, got.sat);
                mismatches++;
            end
            if (got.light !== want.light) begin
                $display("%0t: lightness mismatch: expected %0d, actual %0d",
                         $time, want.light, got.light);
                mismatches++;
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_stall;
    logic [RGB_W-1:0] i_red_level = '0;
    logic [RGB_W-1:0] i_green_level = '0;
    logic [RGB_W-1:0] i_blue_level = '0;
    logic             o_valid;
    logic             i_stall = 1'b0;
    logic [HUE_W-1:0] o_hue_angle;
    logic [PCT_W-1:0] o_saturation_pct;
    logic [PCT_W-1:0] o_lightness_pct;

    hsl_scoreboard sb = new();
    int unsigned   cycle_count = 0;
    bit            tx_burst = 1'b0;
    bit            rx_burst = 1'b0;

    rgb_to_hsl_convert u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_red_level      (i_red_level),
        .i_green_level    (i_green_level),
        .i_blue_level     (i_blue_level),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_hue_angle      (o_hue_angle),
        .o_saturation_pct (o_saturation_pct),
        .o_lightness_pct  (o_lightness_pct)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                sb.note_pixel(i_red_level, i_green_level, i_blue_level);
            if (o_valid && !i_stall)
                sb.check_result('{o_hue_angle, o_saturation_pct, o_lightness_pct});
        end
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timed out after %0d cycles", cycle_count);
        $display("tb: FAIL");
        $finish;
    end

    // Result side: stall for a random number of cycles before each result,
    // with occasional stretches of no stalling at all.
    initial begin : result_sink
        int unsigned hold;
        @(posedge i_rst_n);
        forever begin
            if ($urandom_range(0, 19) == 0) rx_burst = !rx_burst;
            hold = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
            repeat (hold) begin
                @(negedge i_clk);
                i_stall <= 1'b1;
            end
            @(negedge i_clk);
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    task automatic send_pixel(input bit [RGB_W-1:0] r, input bit [RGB_W-1:0] g,
                              input bit [RGB_W-1:0] b);
        int unsigned gap;
        if ($urandom_range(0, 19) == 0) tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_red_level   <= r;
        i_green_level <= g;
        i_blue_level  <= b;
        do @(posedge i_clk); while (o_stall);
    endtask

    function automatic bit [RGB_W-1:0] clip_level(int v);
        if (v < 0) return 8'd0;
        if (v > 255) return 8'd255;
        return v[7:0];
    endfunction

    function automatic bit [RGB_W-1:0] edge_level();
        case ($urandom_range(0, 4))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd1;
            3: return 8'd254;
            default: return RGB_W'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin : stimulus
        bit [23:0]        corner[] = '{
            24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101, 24'hFF0000,
            24'h00FF00, 24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF,
            24'hFF0001, 24'hFE00FF, 24'h010000, 24'hFEFFFF, 24'hC83700,
            24'hC83800, 24'h800000, 24'h00FF01, 24'h7F8080, 24'hFF8000,
            24'h80FF00, 24'h0080FF, 24'hAA55AA, 24'h5555AA
        };
        bit [RGB_W-1:0]   lv[3];
        int               base;
        int               hi_lv;
        int               lo_lv;
        int unsigned      pick;
        int unsigned      failures;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (corner[i])
            send_pixel(corner[i][23:16], corner[i][15:8], corner[i][7:0]);

        repeat (RANDOM_PIXELS) begin
            case ($urandom_range(0, 9))
                4: begin
                    // Grey: all three channels equal.
                    lv[0] = RGB_W'($urandom_range(0, 255));
                    lv[1] = lv[0];
                    lv[2] = lv[0];
                end
                5: begin
                    // Two channels tied, to exercise the priority of the maximum.
                    lv[0] = RGB_W'($urandom_range(0, 255));
                    lv[1] = RGB_W'($urandom_range(0, 255));
                    lv[2] = RGB_W'($urandom_range(0, 255));
                    pick = $urandom_range(0, 2);
                    lv[pick] = lv[(pick + 1) % 3];
                end
                6: begin
                    base = $urandom_range(0, 255);
                    foreach (lv[k])
                        lv[k] = clip_level(base + $signed($urandom_range(0, 6)) - 3);
                end
                7: begin
                    foreach (lv[k]) lv[k] = edge_level();
                end
                8: begin
                    // Sum of maximum and minimum close to the saturation fold point.
                    hi_lv = $urandom_range(128, 255);
                    lo_lv = int'(clip_level(255 - hi_lv + $signed($urandom_range(0, 4)) - 2));
                    if (lo_lv > hi_lv) lo_lv = hi_lv;
                    lv[0] = RGB_W'(hi_lv);
                    lv[1] = RGB_W'(lo_lv);
                    lv[2] = RGB_W'($urandom_range(lo_lv, hi_lv));
                    pick = $urandom_range(0, 2);
                    {lv[0], lv[pick]} = {lv[pick], lv[0]};
                end
                default: begin
                    foreach (lv[k]) lv[k] = RGB_W'($urandom_range(0, 255));
                end
            endcase
            send_pixel(lv[0], lv[1], lv[2]);
        end

        @(negedge i_clk);
        i_valid <= 1'b0;

        while (sb.expected_hsl.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        failures = sb.mismatches + sb.expected_hsl.size();
        $display("Converted %0d pixels (%0d corner cases), checked %0d results",
                 sb.pixels_in, corner.size(), sb.results_checked);
        $display("Random idling on both sides over %0d cycles, %0d mismatches",
                 cycle_count, failures);
        if (failures == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

FILE: rgb_to_hsl_convert.f
sv/rgb2hsl_pkg.sv
sv/rgb2hsl_front.sv
sv/rgb2hsl_div.sv
sv/rgb_to_hsl_convert.sv
test/tb.sv
